>>> src/can_multiframe_reassembly_core_assert.svh
// ----------------------------------------------------------------------------
// can multiframe reassembly assertion macros
// shared concurrent check forms used by the reassembly rtl
// ----------------------------------------------------------------------------
`ifndef CAN_MULTIFRAME_REASSEMBLY_CORE_ASSERT_SVH
`define CAN_MULTIFRAME_REASSEMBLY_CORE_ASSERT_SVH

// same-cycle implication
`define CMR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cmr same-cycle check failed");

// next-cycle implication
`define CMR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmr next-cycle check failed");

`endif

>>> src/cmr_pkg.sv
// ----------------------------------------------------------------------------
// cmr_pkg
// types, sizes and codes shared by the can multiframe reassembly block
// ----------------------------------------------------------------------------
`default_nettype none

package cmr_pkg;

  localparam int SLOT_COUNT        = 4;
  localparam int MAX_MESSAGE_BYTES = 64;
  localparam int FRAME_BYTES       = 8;

  localparam int SLOT_W    = $clog2(SLOT_COUNT);
  localparam int FILL_W    = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int MEM_DEPTH = SLOT_COUNT * MAX_MESSAGE_BYTES;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CNT_W     = 16;
  localparam int LEN_W     = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic       REQ_FRAME = 1'b0;
  localparam logic       REQ_DRAIN = 1'b1;
  localparam logic [10:0] ID_START = 11'd0;
  localparam logic [10:0] ID_DATA  = 11'd1;
  localparam logic [10:0] ID_END   = 11'd2;

  typedef enum logic [1:0] {
    SLOT_EMPTY     = 2'd0,
    SLOT_RECEIVING = 2'd1,
    SLOT_READY     = 2'd2
  } slot_status_t;

  typedef struct packed {
    logic        req_type;
    logic        is_remote;
    logic [10:0] frame_id;
    logic [3:0]  byte_count;
    logic [7:0]  data_0;
    logic [7:0]  data_1;
    logic [7:0]  data_2;
    logic [7:0]  data_3;
    logic [7:0]  data_4;
    logic [7:0]  data_5;
    logic [7:0]  data_6;
    logic [7:0]  data_7;
  } cmr_req_t;

  typedef struct packed {
    logic             message_valid;
    logic [7:0]       message_byte;
    logic [5:0]       byte_offset;
    logic [6:0]       topic_size;
    logic [6:0]       payload_size;
    logic             last_of_run;
    logic [CNT_W-1:0] dropped_total;
    logic [CNT_W-1:0] interrupted_total;
    logic [CNT_W-1:0] oversize_total;
    logic [CNT_W-1:0] mismatch_total;
  } cmr_rsp_t;

  typedef struct packed {
    logic dropped;
    logic interrupted;
    logic oversize;
    logic mismatch;
  } cnt_bump_t;

  typedef struct packed {
    logic [CNT_W-1:0] dropped;
    logic [CNT_W-1:0] interrupted;
    logic [CNT_W-1:0] oversize;
    logic [CNT_W-1:0] mismatch;
  } cnt_set_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(SLOT_COUNT - 1)) begin
      return '0;
    end
    return s + SLOT_W'(1);
  endfunction

endpackage

`default_nettype wire

>>> src/cmr_err_cnt.sv
// ----------------------------------------------------------------------------
// cmr_err_cnt
// four saturating error counters, cleared together at the end of a drain
// ----------------------------------------------------------------------------
`default_nettype none

module cmr_err_cnt
  import cmr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cnt_bump_t bump,
  input  wire logic      clear,
  output cnt_set_t       counts
);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
    return (en && v != CNT_MAX) ? v + CNT_W'(1) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      counts <= '0;
    end else begin
      counts.dropped     <= sat_inc(counts.dropped, bump.dropped);
      counts.interrupted <= sat_inc(counts.interrupted, bump.interrupted);
      counts.oversize    <= sat_inc(counts.oversize, bump.oversize);
      counts.mismatch    <= sat_inc(counts.mismatch, bump.mismatch);
    end
  end

endmodule

`default_nettype wire

>>> src/can_multiframe_reassembly_core.sv
// ----------------------------------------------------------------------------
// can_multiframe_reassembly_core
// collects multi-frame can messages into a ring of buffer slots and drains
// them one byte per result
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid/req_ready/req_data) carries either a received can
//   frame or a drain request. rsp channel (rsp_valid/rsp_ready/rsp_data)
//   carries one result per drained byte, a single one when no bytes are
//   ready; frames never produce results. a start frame, an ignored frame
//   or a rejected append is handled in the idle state. a data or end frame
//   enters a fill state that writes its stored bytes through the buffer
//   memory write port, one byte per cycle. a drain takes a memory read,
//   then an output load, for each result.
//   only one request is in work at a time; req_ready is high while idle,
//   even while the last result still waits in the output register.
//   reset: all slots empty, ring pointers and error counters zero; no
//   clearing pass, buffer bytes only reach the output after being written.
//   a stalled receiver holds the output register; the drain pauses with the
//   next byte parked in the memory read register until rsp_ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

`include "can_multiframe_reassembly_core_assert.svh"

module can_multiframe_reassembly_core
  import cmr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire cmr_req_t req_data,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output cmr_rsp_t      rsp_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FILL = 4'b0010,
    S_READ = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t state;

  // per-slot bookkeeping
  slot_status_t      slot_status  [SLOT_COUNT];
  logic [LEN_W-1:0]  slot_topic   [SLOT_COUNT];
  logic [LEN_W-1:0]  slot_payload [SLOT_COUNT];
  logic [FILL_W-1:0] slot_fill    [SLOT_COUNT];
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] rd_slot;

  // message byte store
  logic [7:0]        msg_mem [MEM_DEPTH];
  logic [7:0]        rd_q;

  // frame being appended
  logic [7:0]        fbytes [FRAME_BYTES];
  logic [3:0]        fcount;
  logic [3:0]        fidx;
  logic              fend;

  // drain run
  logic              run_ready;
  logic              run_bytes;
  logic [FILL_W-1:0] run_count;
  logic [LEN_W-1:0]  run_topic;
  logic [6:0]        run_payload;
  logic [FILL_W-1:0] k;

  cnt_bump_t         bump;
  cnt_set_t          counts;
  logic              cnt_clear;

  logic              req_fire;
  logic              is_frame;
  slot_status_t      cur_status;
  logic              start_hit;
  logic              append_hit;
  logic [3:0]        n_clamp;
  logic [FILL_W:0]   fill_sum;
  logic              overflow;
  logic              fill_done;
  logic [FILL_W-1:0] new_fill;
  logic [LEN_W:0]    want;
  logic              len_match;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              load_ok;
  logic              last_k;
  logic              term_hit;
  cmr_rsp_t          rsp_next;

  assign req_ready  = (state == S_IDLE);
  assign req_fire   = req_valid && req_ready;
  assign is_frame   = req_fire && (req_data.req_type == REQ_FRAME) && !req_data.is_remote;
  assign cur_status = slot_status[wr_slot];
  assign start_hit  = is_frame && (req_data.frame_id == ID_START);
  assign append_hit = is_frame && cur_status == SLOT_RECEIVING &&
                      (req_data.frame_id == ID_DATA || req_data.frame_id == ID_END);
  assign n_clamp    = (req_data.byte_count > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES)
                                                              : req_data.byte_count;
  assign fill_sum   = (FILL_W + 1)'(slot_fill[wr_slot]) + (FILL_W + 1)'(n_clamp);
  assign overflow   = append_hit && (fill_sum > (FILL_W + 1)'(MAX_MESSAGE_BYTES));

  assign fill_done  = (state == S_FILL) && (fidx == fcount);
  assign new_fill   = slot_fill[wr_slot] + FILL_W'(fcount);
  assign want       = (LEN_W + 1)'(slot_topic[wr_slot]) + (LEN_W + 1)'(slot_payload[wr_slot]);
  assign len_match  = ((LEN_W + 1)'(new_fill) == want);

  assign bump.dropped     = start_hit && cur_status == SLOT_READY;
  assign bump.interrupted = start_hit && cur_status == SLOT_RECEIVING;
  assign bump.oversize    = overflow;
  assign bump.mismatch    = fill_done && fend && !len_match;

  assign mem_we    = (state == S_FILL) && (fidx != fcount);
  assign mem_waddr = ADDR_W'(wr_slot) * ADDR_W'(MAX_MESSAGE_BYTES) +
                     ADDR_W'(slot_fill[wr_slot]) + ADDR_W'(fidx);
  assign mem_re    = (state == S_READ);
  assign mem_raddr = ADDR_W'(rd_slot) * ADDR_W'(MAX_MESSAGE_BYTES) + ADDR_W'(k);

  assign load_ok   = (state == S_LOAD) && (!rsp_valid || rsp_ready);
  assign last_k    = (k == run_count - FILL_W'(1));
  assign cnt_clear = load_ok && last_k;

  // the topic terminator reads as zero instead of being written back
  assign term_hit  = (run_topic != '0) && (LEN_W'(k) == run_topic - LEN_W'(1));

  always_comb begin
    rsp_next                   = '0;
    rsp_next.message_valid     = run_ready;
    rsp_next.message_byte      = (run_bytes && !term_hit) ? rd_q : 8'd0;
    rsp_next.byte_offset       = run_ready ? 6'(k) : 6'd0;
    rsp_next.topic_size        = run_ready ? run_topic[6:0] : 7'd0;
    rsp_next.payload_size      = run_ready ? run_payload : 7'd0;
    rsp_next.last_of_run       = last_k;
    rsp_next.dropped_total     = counts.dropped;
    rsp_next.interrupted_total = counts.interrupted;
    rsp_next.oversize_total    = counts.oversize;
    rsp_next.mismatch_total    = counts.mismatch;
  end

  // frame writes and drain reads never overlap: one request at a time
  always_ff @(posedge clk) begin
    if (mem_we) begin
      msg_mem[mem_waddr] <= fbytes[fidx[2:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_q <= msg_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wr_slot <= '0;
      rd_slot <= '0;
      for (int j = 0; j < SLOT_COUNT; j++) begin
        slot_status[j]  <= SLOT_EMPTY;
        slot_topic[j]   <= '0;
        slot_payload[j] <= '0;
        slot_fill[j]    <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_fire && req_data.req_type == REQ_DRAIN) begin
            run_ready   <= (slot_status[rd_slot] == SLOT_READY);
            run_bytes   <= (slot_status[rd_slot] == SLOT_READY) && (slot_fill[rd_slot] != '0);
            run_count   <= (slot_status[rd_slot] == SLOT_READY && slot_fill[rd_slot] != '0)
                           ? slot_fill[rd_slot] : FILL_W'(1);
            run_topic   <= slot_topic[rd_slot];
            run_payload <= slot_payload[rd_slot][6:0];
            k           <= '0;
            state       <= S_READ;
          end else if (start_hit && cur_status != SLOT_READY) begin
            slot_status[wr_slot]  <= SLOT_RECEIVING;
            slot_topic[wr_slot]   <= {req_data.data_0, req_data.data_1};
            slot_payload[wr_slot] <= {req_data.data_2, req_data.data_3};
            slot_fill[wr_slot]    <= '0;
          end else if (overflow) begin
            slot_status[wr_slot] <= SLOT_EMPTY;
          end else if (append_hit) begin
            fbytes[0] <= req_data.data_0;
            fbytes[1] <= req_data.data_1;
            fbytes[2] <= req_data.data_2;
            fbytes[3] <= req_data.data_3;
            fbytes[4] <= req_data.data_4;
            fbytes[5] <= req_data.data_5;
            fbytes[6] <= req_data.data_6;
            fbytes[7] <= req_data.data_7;
            fcount    <= n_clamp;
            fidx      <= '0;
            fend      <= (req_data.frame_id == ID_END);
            state     <= S_FILL;
          end
        end
        S_FILL: begin
          if (fill_done) begin
            slot_fill[wr_slot] <= new_fill;
            if (fend) begin
              if (len_match) begin
                slot_status[wr_slot] <= SLOT_READY;
                wr_slot              <= next_slot(wr_slot);
              end else begin
                slot_status[wr_slot] <= SLOT_EMPTY;
              end
            end
            state <= S_IDLE;
          end else begin
            fidx <= fidx + 4'd1;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (load_ok) begin
            if (last_k) begin
              if (run_ready) begin
                slot_status[rd_slot] <= SLOT_EMPTY;
                rd_slot              <= next_slot(rd_slot);
              end
              state <= S_IDLE;
            end else begin
              k     <= k + FILL_W'(1);
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_ok) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      rsp_data <= rsp_next;
    end
  end

  cmr_err_cnt u_err_cnt (
    .clk    (clk),
    .rst    (rst),
    .bump   (bump),
    .clear  (cnt_clear),
    .counts (counts)
  );

  `CMR_ASSERT_IMP(a_fill_on_receiving, clk, rst, state == S_FILL, slot_status[wr_slot] == SLOT_RECEIVING)
  `CMR_ASSERT_IMP(a_k_in_run, clk, rst, state == S_READ || state == S_LOAD, k < run_count)
  `CMR_ASSERT_NXT(a_drain_starts, clk, rst, req_fire && req_data.req_type == REQ_DRAIN, state == S_READ)
  `CMR_ASSERT_NXT(a_slot_released, clk, rst, load_ok && last_k && run_ready, slot_status[$past(rd_slot)] == SLOT_EMPTY && rd_slot != $past(rd_slot))

endmodule

`default_nettype wire
